[src/hrsp_pkg.sv]
// Package for the HTTP request stream parser: phases, codes and limits.
// Used by the phase engine and the top level.
package hrsp_pkg;

  localparam int BODY_LENGTH_BITS = 32;
  localparam int FIELD_W = 13;
  localparam logic [FIELD_W-1:0] FIELD_MAX = 13'd8191;

  typedef enum logic [3:0] {
    PH_METHOD    = 4'd0,
    PH_URI       = 4'd1,
    PH_VERSION   = 4'd2,
    PH_KEY       = 4'd3,
    PH_VALUE     = 4'd4,
    PH_BODY_LEN  = 4'd5,
    PH_CSIZE     = 4'd6,
    PH_CDATA     = 4'd7,
    PH_CDATA_END = 4'd8,
    PH_CLAST     = 4'd9,
    PH_DONE      = 4'd10,
    PH_SINK      = 4'd11
  } phase_t;

  typedef enum logic [3:0] {
    ERR_NONE     = 4'd0,
    ERR_NO_END   = 4'd1,
    ERR_REQ_LINE = 4'd2,
    ERR_METHOD   = 4'd3,
    ERR_URI      = 4'd4,
    ERR_VERSION  = 4'd5,
    ERR_NO_COLON = 4'd6,
    ERR_EMPTY    = 4'd7,
    ERR_TOO_LONG = 4'd8,
    ERR_NO_HOST  = 4'd9,
    ERR_SHORT    = 4'd10,
    ERR_CHUNK    = 4'd11
  } err_t;

  typedef enum logic [2:0] {
    KIND_SKIP = 3'd0, KIND_METHOD = 3'd1, KIND_URI = 3'd2, KIND_VERSION = 3'd3,
    KIND_KEY = 3'd4, KIND_VALUE = 3'd5, KIND_BODY = 3'd6
  } kind_t;

  localparam logic [1:0] METH_NONE = 2'd0;
  localparam logic [1:0] METH_GET  = 2'd1;
  localparam logic [1:0] METH_POST = 2'd2;

  localparam logic [1:0] HN_NONE = 2'd0;
  localparam logic [1:0] HN_HOST = 2'd1;
  localparam logic [1:0] HN_CLEN = 2'd2;
  localparam logic [1:0] HN_TENC = 2'd3;

  localparam logic [1:0] CFG_URI   = 2'd0;
  localparam logic [1:0] CFG_KEY   = 2'd1;
  localparam logic [1:0] CFG_VALUE = 2'd2;

  typedef logic [BODY_LENGTH_BITS-1:0] body_len_t;
  localparam body_len_t BODY_ALL_ONES = '1;

  typedef struct packed {
    logic [7:0]         out_byte;
    logic [2:0]         byte_kind;
    logic               value_blank;
    logic               field_end;
    logic [3:0]         error_code;
    logic [1:0]         method_code;
    logic               message_done;
  } result_t;

  typedef struct packed {
    logic [FIELD_W-1:0] max_uri_length;
    logic [FIELD_W-1:0] max_key_length;
    logic [FIELD_W-1:0] max_value_length;
  } limits_t;

  // Character of a literal at a position; zero beyond its end.
  function automatic logic [7:0] meth_char(input logic [1:0] m, input logic [4:0] i);
    logic [7:0] c;
    c = 8'h00;
    case (m)
      METH_GET:  c = (i == 5'd0) ? "G" : (i == 5'd1) ? "E" : (i == 5'd2) ? "T" : 8'h00;
      METH_POST: c = (i == 5'd0) ? "P" : (i == 5'd1) ? "O" : (i == 5'd2) ? "S" :
                     (i == 5'd3) ? "T" : 8'h00;
      default:   c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [4:0] meth_len(input logic [1:0] m);
    logic [4:0] l;
    case (m)
      METH_GET:  l = 5'd3;
      METH_POST: l = 5'd4;
      default:   l = 5'd0;
    endcase
    return l;
  endfunction

  function automatic logic [7:0] name_char(input logic [1:0] c, input logic [4:0] i);
    logic [7:0] r;
    r = 8'h00;
    case (c)
      HN_HOST: case (i)
        5'd0: r = "h"; 5'd1: r = "o"; 5'd2: r = "s"; 5'd3: r = "t";
        default: r = 8'h00;
      endcase
      HN_CLEN: case (i)
        5'd0: r = "c"; 5'd1: r = "o"; 5'd2: r = "n"; 5'd3: r = "t"; 5'd4: r = "e";
        5'd5: r = "n"; 5'd6: r = "t"; 5'd7: r = "-"; 5'd8: r = "l"; 5'd9: r = "e";
        5'd10: r = "n"; 5'd11: r = "g"; 5'd12: r = "t"; 5'd13: r = "h";
        default: r = 8'h00;
      endcase
      HN_TENC: case (i)
        5'd0: r = "t"; 5'd1: r = "r"; 5'd2: r = "a"; 5'd3: r = "n"; 5'd4: r = "s";
        5'd5: r = "f"; 5'd6: r = "e"; 5'd7: r = "r"; 5'd8: r = "-"; 5'd9: r = "e";
        5'd10: r = "n"; 5'd11: r = "c"; 5'd12: r = "o"; 5'd13: r = "d";
        5'd14: r = "i"; 5'd15: r = "n"; 5'd16: r = "g";
        default: r = 8'h00;
      endcase
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] name_len(input logic [1:0] c);
    logic [4:0] l;
    case (c)
      HN_HOST: l = 5'd4;
      HN_CLEN: l = 5'd14;
      HN_TENC: l = 5'd17;
      default: l = 5'd0;
    endcase
    return l;
  endfunction

  function automatic logic [7:0] version_char(input logic [4:0] i);
    logic [7:0] c;
    case (i)
      5'd0: c = "H"; 5'd1: c = "T"; 5'd2: c = "T"; 5'd3: c = "P"; 5'd4: c = "/";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] chunked_char(input logic [4:0] i);
    logic [7:0] c;
    case (i)
      5'd0: c = "c"; 5'd1: c = "h"; 5'd2: c = "u"; 5'd3: c = "n"; 5'd4: c = "k";
      5'd5: c = "e"; 5'd6: c = "d";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic uri_allowed(input logic [7:0] b);
    logic ok;
    ok = (b >= "A" && b <= "Z") || (b >= "a" && b <= "z") || (b >= "0" && b <= "9");
    case (b)
      "-", ".", "_", "~", ":", "/", "?", "#", "[", "]", "@", "!", "$", "&", "'",
      "(", ")", "*", "+", ",", ";", "=": ok = 1'b1;
      default: ;
    endcase
    return ok;
  endfunction

endpackage

[src/hrsp_in_if.sv]
// Input channel interface: one request byte and its end-of-message mark.
// Depends on nothing else.
interface hrsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, data_byte, last_byte, input ready);
  modport sink (input valid, data_byte, last_byte, output ready);
endinterface

[src/hrsp_out_if.sv]
// Output channel interface: one labelled byte per request byte.
// Depends on nothing else.
interface hrsp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [2:0] byte_kind;
  logic       value_blank;
  logic       field_end;
  logic [3:0] error_code;
  logic [1:0] method_code;
  logic       message_done;
  modport source (output valid, out_byte, byte_kind, value_blank, field_end, error_code,
                  method_code, message_done, input ready);
  modport sink (input valid, out_byte, byte_kind, value_blank, field_end, error_code,
                method_code, message_done, output ready);
endinterface

[src/hrsp_engine.sv]
// Parse state and per-byte labelling logic; one byte per enabled cycle.
// Depends on hrsp_pkg.
module hrsp_engine (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        b,
  input  logic              last,
  input  hrsp_pkg::limits_t lim,
  output hrsp_pkg::result_t res
);
  import hrsp_pkg::*;

  phase_t             phase, phase_next;
  logic               crlf, crlf_next;
  logic [FIELD_W-1:0] flen, flen_next;
  logic [FIELD_W-1:0] vlen, vlen_next;
  logic [4:0]         lidx, lidx_next;
  logic [1:0]         hclass, hclass_next;
  logic [1:0]         meth, meth_next;
  logic               host, host_next;
  logic               chunked, chunked_next;
  logic               lenk, lenk_next;
  body_len_t          rem, rem_next;
  logic               hexs, hexs_next;
  logic [3:0]         err, err_next;

  logic [7:0]  ob;
  logic [2:0]  kind;
  logic        blank, fend, is_blank;
  logic [1:0]  m;
  logic [4:0]  lidx_bump;
  logic [3:0]  hexd;
  logic        hexok;
  logic [BODY_LENGTH_BITS+3:0] dec_prod, hex_prod;
  logic [FIELD_W:0] pos1;

  always_comb begin
    lidx_bump = (lidx < 5'd31) ? lidx + 5'd1 : lidx;
    is_blank = (b == " ") || (b == 8'h09);
    pos1 = {1'b0, flen} + 14'd1;
    hexok = 1'b1;
    hexd = 4'd0;
    if (b >= "0" && b <= "9") hexd = 4'(b - "0");
    else if (b >= "a" && b <= "f") hexd = 4'(b - "a" + 8'd10);
    else if (b >= "A" && b <= "F") hexd = 4'(b - "A" + 8'd10);
    else hexok = 1'b0;
    // the high bits flag overflow of the shifted value
    dec_prod = {4'd0, rem} * (BODY_LENGTH_BITS+4)'(10) +
               {{(BODY_LENGTH_BITS){1'b0}}, 4'(b - "0")};
    hex_prod = {rem, 4'd0} + {{(BODY_LENGTH_BITS){1'b0}}, hexd};
  end

  always_comb begin
    phase_next = phase; crlf_next = crlf; flen_next = flen; vlen_next = vlen;
    lidx_next = lidx; hclass_next = hclass; meth_next = meth; host_next = host;
    chunked_next = chunked; lenk_next = lenk; rem_next = rem; hexs_next = hexs;
    err_next = err;
    ob = b; kind = KIND_SKIP; blank = 1'b0; fend = 1'b0; m = meth;

    if (phase != PH_SINK && crlf) begin
      crlf_next = 1'b0;
      if (b != 8'h0A) begin
        if (err == ERR_NONE)
          err_next = (phase == PH_VERSION) ? ERR_REQ_LINE :
                     (phase == PH_KEY || phase == PH_VALUE) ? ERR_NO_COLON : ERR_CHUNK;
        phase_next = PH_SINK;
      end else begin
        flen_next = '0; vlen_next = '0; lidx_next = '0; hclass_next = HN_NONE;
        hexs_next = 1'b0;
        case (phase)
          PH_VERSION, PH_VALUE: phase_next = PH_KEY;
          PH_KEY: begin
            if (!host) begin
              if (err == ERR_NONE) err_next = ERR_NO_HOST;
              phase_next = PH_SINK;
              flen_next = flen; vlen_next = vlen; lidx_next = lidx;
              hclass_next = hclass; hexs_next = hexs;
            end else if (lenk)
              phase_next = (rem == '0) ? PH_DONE : PH_BODY_LEN;
            else if (chunked) begin
              rem_next = '0;
              phase_next = PH_CSIZE;
            end else phase_next = PH_DONE;
          end
          PH_CSIZE: phase_next = (rem == '0) ? PH_CLAST : PH_CDATA;
          PH_CDATA_END: begin
            rem_next = '0;
            phase_next = PH_CSIZE;
          end
          default: phase_next = PH_DONE;
        endcase
      end
    end else begin
      case (phase)
        PH_METHOD: begin
          if (b == 8'h0D) begin
            err_next = (err == ERR_NONE) ? ERR_REQ_LINE : err;
            meth_next = METH_NONE; phase_next = PH_SINK;
          end else if (b == " ") begin
            if (meth == METH_NONE || meth == 2'd3 || lidx != meth_len(meth)) begin
              err_next = (err == ERR_NONE) ? ERR_METHOD : err;
              meth_next = METH_NONE; phase_next = PH_SINK;
            end else begin
              fend = 1'b1;
              phase_next = PH_URI; flen_next = '0; vlen_next = '0; lidx_next = '0;
              hclass_next = HN_NONE; hexs_next = 1'b0;
            end
          end else begin
            m = (meth == 2'd3) ? METH_NONE : meth;
            if (lidx == 5'd0)
              m = (b == "G") ? METH_GET : (b == "P") ? METH_POST : METH_NONE;
            else if (m != METH_NONE && (lidx >= meth_len(m) || meth_char(m, lidx) != b))
              m = METH_NONE;
            meth_next = m;
            lidx_next = lidx_bump;
            kind = KIND_METHOD;
          end
        end
        PH_URI: begin
          if (b == 8'h0D) begin
            err_next = (err == ERR_NONE) ? ERR_REQ_LINE : err; phase_next = PH_SINK;
          end else if (b == " ") begin
            if (flen == '0) begin
              err_next = (err == ERR_NONE) ? ERR_URI : err; phase_next = PH_SINK;
            end else begin
              fend = 1'b1;
              phase_next = PH_VERSION; flen_next = '0; vlen_next = '0; lidx_next = '0;
              hclass_next = HN_NONE; hexs_next = 1'b0;
            end
          end else if (flen >= lim.max_uri_length || !uri_allowed(b)) begin
            err_next = (err == ERR_NONE) ? ERR_URI : err; phase_next = PH_SINK;
          end else begin
            flen_next = flen + 13'd1;
            kind = KIND_URI;
          end
        end
        PH_VERSION: begin
          if (b == " ") begin
            err_next = (err == ERR_NONE) ? ERR_REQ_LINE : err; phase_next = PH_SINK;
          end else if (b == 8'h0D) begin
            if (lidx < 5'd5) begin
              err_next = (err == ERR_NONE) ? ERR_VERSION : err; phase_next = PH_SINK;
            end else begin
              fend = 1'b1; crlf_next = 1'b1;
            end
          end else if (lidx < 5'd5 && b != version_char(lidx)) begin
            err_next = (err == ERR_NONE) ? ERR_VERSION : err; phase_next = PH_SINK;
          end else begin
            lidx_next = lidx_bump;
            kind = KIND_VERSION;
          end
        end
        PH_KEY: begin
          if (b == 8'h0D) begin
            if (flen == '0) crlf_next = 1'b1;
            else begin
              err_next = (err == ERR_NONE) ? ERR_NO_COLON : err; phase_next = PH_SINK;
            end
          end else if (b == ":") begin
            if (flen == '0) begin
              err_next = (err == ERR_NONE) ? ERR_EMPTY : err; phase_next = PH_SINK;
            end else begin
              m = (lidx != name_len(hclass)) ? HN_NONE : hclass;
              fend = 1'b1;
              phase_next = PH_VALUE; flen_next = '0; vlen_next = '0; lidx_next = '0;
              hexs_next = 1'b0; hclass_next = m;
              if (m == HN_CLEN) rem_next = '0;
            end
          end else if (flen >= lim.max_key_length) begin
            err_next = (err == ERR_NONE) ? ERR_TOO_LONG : err; phase_next = PH_SINK;
          end else begin
            if (b >= "A" && b <= "Z") ob = b + 8'd32;
            m = hclass;
            if (lidx == 5'd0)
              m = (ob == "h") ? HN_HOST : (ob == "c") ? HN_CLEN : (ob == "t") ? HN_TENC : HN_NONE;
            else if (m != HN_NONE && (lidx >= name_len(m) || name_char(m, lidx) != ob))
              m = HN_NONE;
            hclass_next = m;
            flen_next = flen + 13'd1;
            lidx_next = lidx_bump;
            kind = KIND_KEY;
          end
        end
        PH_VALUE: begin
          if (b == 8'h0D) begin
            if (vlen == '0) begin
              err_next = (err == ERR_NONE) ? ERR_EMPTY : err; phase_next = PH_SINK;
            end else if (hclass == HN_CLEN && !hexs) begin
              err_next = (err == ERR_NONE) ? ERR_SHORT : err; phase_next = PH_SINK;
            end else begin
              if (hclass == HN_HOST) host_next = 1'b1;
              if (hclass == HN_CLEN) lenk_next = 1'b1;
              if (hclass == HN_TENC) chunked_next = (lidx == 5'd7);
              crlf_next = 1'b1;
              fend = 1'b1;
            end
          end else if (is_blank) begin
            blank = 1'b1; kind = KIND_VALUE;
            if (vlen != '0) begin
              if (flen < FIELD_MAX) flen_next = flen + 13'd1;
              if (hclass == HN_CLEN && hexs) lidx_next = 5'd2;
            end
          end else if (pos1 > {1'b0, lim.max_value_length}) begin
            err_next = (err == ERR_NONE) ? ERR_TOO_LONG : err; phase_next = PH_SINK;
          end else begin
            kind = KIND_VALUE;
            flen_next = pos1[FIELD_W-1:0];
            vlen_next = pos1[FIELD_W-1:0];
            if (hclass == HN_CLEN) begin
              if (b >= "0" && b <= "9" && lidx == 5'd0) begin
                rem_next = (dec_prod[BODY_LENGTH_BITS+3:BODY_LENGTH_BITS] != 4'd0) ?
                           BODY_ALL_ONES : dec_prod[BODY_LENGTH_BITS-1:0];
                hexs_next = 1'b1;
              end else lidx_next = 5'd2;
            end else if (hclass == HN_TENC) begin
              if (lidx < 5'd7 && flen == {8'd0, lidx} && b == chunked_char(lidx))
                lidx_next = lidx + 5'd1;
              else lidx_next = 5'd31;
            end
          end
        end
        PH_BODY_LEN, PH_CDATA: begin
          kind = KIND_BODY;
          rem_next = rem - 1'b1;
          if (rem_next == '0) phase_next = (phase == PH_CDATA) ? PH_CDATA_END : PH_DONE;
        end
        PH_CSIZE: begin
          if (b == 8'h0D) begin
            if (!hexs) begin
              err_next = (err == ERR_NONE) ? ERR_CHUNK : err; phase_next = PH_SINK;
            end else crlf_next = 1'b1;
          end else if (is_blank) begin
            if (hexs) lidx_next = 5'd2;
          end else if (hexok && lidx == 5'd0) begin
            rem_next = (hex_prod[BODY_LENGTH_BITS+3:BODY_LENGTH_BITS] != 4'd0) ?
                       BODY_ALL_ONES : hex_prod[BODY_LENGTH_BITS-1:0];
            hexs_next = 1'b1;
          end else lidx_next = 5'd2;
        end
        PH_CDATA_END, PH_CLAST: begin
          if (b == 8'h0D) crlf_next = 1'b1;
          else begin
            err_next = (err == ERR_NONE) ? ERR_CHUNK : err; phase_next = PH_SINK;
          end
        end
        default: ;
      endcase
    end

    if (last) begin
      case (phase_next)
        PH_METHOD, PH_URI, PH_VERSION, PH_KEY, PH_VALUE: begin
          if (err_next == ERR_NONE) err_next = ERR_NO_END;
          if (phase_next == PH_METHOD) meth_next = METH_NONE;
          phase_next = PH_SINK;
        end
        PH_BODY_LEN: begin
          if (err_next == ERR_NONE) err_next = ERR_SHORT;
          phase_next = PH_SINK;
        end
        PH_CSIZE, PH_CDATA, PH_CDATA_END, PH_CLAST: begin
          if (err_next == ERR_NONE) err_next = ERR_CHUNK;
          phase_next = PH_SINK;
        end
        default: ;
      endcase
    end
    if (phase_next == PH_SINK) begin
      crlf_next = 1'b0;
      kind = KIND_SKIP; blank = 1'b0; fend = 1'b0; ob = b;
    end

    res.out_byte = ob;
    res.byte_kind = kind;
    res.value_blank = blank;
    res.field_end = fend;
    res.error_code = err_next;
    res.method_code = (phase_next != PH_METHOD) ? meth_next : METH_NONE;
    res.message_done = last;
  end

  always_ff @(posedge clk) begin
    if (rst || (step && last)) begin
      phase <= PH_METHOD; crlf <= 1'b0; flen <= '0; vlen <= '0; lidx <= '0;
      hclass <= HN_NONE; meth <= METH_NONE; host <= 1'b0; chunked <= 1'b0;
      lenk <= 1'b0; rem <= '0; hexs <= 1'b0; err <= ERR_NONE;
    end else if (step) begin
      phase <= phase_next; crlf <= crlf_next; flen <= flen_next; vlen <= vlen_next;
      lidx <= lidx_next; hclass <= hclass_next; meth <= meth_next; host <= host_next;
      chunked <= chunked_next; lenk <= lenk_next; rem <= rem_next; hexs <= hexs_next;
      err <= err_next;
    end
  end

endmodule

[src/http_request_stream_parser_core.sv]
// HTTP request stream parser: labels each request byte, checks framing.
// An accepted byte's result is in the output register in the cycle after it is taken.
// Throughput: one byte per cycle; ready stays high unless the output register
// holds a result that is not taken. Reset (rst, synchronous) clears parse state
// and loads the limit registers with 2048, 256 and 4096.
module http_request_stream_parser_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  hrsp_in_if.sink     in_ch,
  hrsp_out_if.source  out_ch
);
  import hrsp_pkg::*;

  limits_t lim;
  result_t res, held;
  logic    take, full;

  assign take = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !full || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      lim.max_uri_length   <= 13'd2048;
      lim.max_key_length   <= 13'd256;
      lim.max_value_length <= 13'd4096;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_URI:   lim.max_uri_length   <= cfg_data;
        CFG_KEY:   lim.max_key_length   <= cfg_data;
        CFG_VALUE: lim.max_value_length <= cfg_data;
        default: ;
      endcase
    end
  end

  hrsp_engine u_engine (
    .clk  (clk),
    .rst  (rst),
    .step (take),
    .b    (in_ch.data_byte),
    .last (in_ch.last_byte),
    .lim  (lim),
    .res  (res)
  );

  // hold the result until it is taken downstream
  always_ff @(posedge clk) begin
    if (rst) full <= 1'b0;
    else if (take) full <= 1'b1;
    else if (out_ch.ready) full <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (take) held <= res;
  end

  assign out_ch.valid        = full;
  assign out_ch.out_byte     = held.out_byte;
  assign out_ch.byte_kind    = held.byte_kind;
  assign out_ch.value_blank  = held.value_blank;
  assign out_ch.field_end    = held.field_end;
  assign out_ch.error_code   = held.error_code;
  assign out_ch.method_code  = held.method_code;
  assign out_ch.message_done = held.message_done;

  a_ready: assert property (@(posedge clk) disable iff (rst) !full |-> in_ch.ready)
    else $error("ready low with empty output register");
  a_fill: assert property (@(posedge clk) disable iff (rst) take |=> out_ch.valid)
    else $error("accepted request produced no result");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.ready) |=> $stable(held))
    else $error("stalled result changed");
  a_skip: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.error_code != ERR_NONE && out_ch.message_done) |->
    (out_ch.byte_kind == KIND_SKIP))
    else $error("labelled byte after an error at end of message");

endmodule
